@@ hdl/dfs_pkg.sv @@
package dfs_pkg;

  localparam int MAX_WIDTH = 32;
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int LVL_W     = 4;
  localparam int WIDTH_W   = 6;
  localparam int HEIGHT_W  = 10;
  localparam int GLYPH_W   = 7;

  localparam logic [LVL_W-1:0] LVL_MAX = 4'd9;

  localparam logic [0:0] REG_WIDTH  = 1'b0;
  localparam logic [0:0] REG_HEIGHT = 1'b1;

  localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 6'd30;
  localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 10'd20;

  typedef struct packed {
    logic [LVL_W-1:0] odd;
    logic [LVL_W-1:0] even;
  } pair_t;

  typedef struct packed {
    logic [LVL_W-1:0] centre;
    logic [LVL_W-1:0] right;
    logic [LVL_W-1:0] down;
    logic [LVL_W-1:0] left;
    logic [LVL_W-1:0] up;
    logic             has_right;
    logic             has_down;
    logic             has_left;
    logic             has_up;
  } clean_req_t;

  function automatic logic [LVL_W-1:0] pick(input pair_t p, input logic bank);
    return bank ? p.odd : p.even;
  endfunction

  function automatic logic [GLYPH_W-1:0] shade(input logic [LVL_W-1:0] lvl);
    logic [GLYPH_W-1:0] g;
    case (lvl)
      4'd0:    g = 7'd32;
      4'd1:    g = 7'd46;
      4'd2:    g = 7'd39;
      4'd3:    g = 7'd58;
      4'd4:    g = 7'd126;
      4'd5:    g = 7'd42;
      4'd6:    g = 7'd61;
      4'd7:    g = 7'd38;
      4'd8:    g = 7'd37;
      default: g = 7'd35;
    endcase
    return g;
  endfunction

endpackage

@@ hdl/dfs_cell.sv @@
module dfs_cell (
  input  logic                    clk,
  input  logic                    shift,
  input  dfs_pkg::pair_t          d,
  input  logic                    wr,
  input  logic                    wr_bank,
  input  logic [dfs_pkg::LVL_W-1:0] wr_data,
  output dfs_pkg::pair_t          q,
  output dfs_pkg::pair_t          fwd
);

  dfs_pkg::pair_t val_r;

  always_comb begin
    q   = val_r;
    fwd = val_r;
    if (wr) begin
      if (wr_bank) begin
        fwd.odd = wr_data;
      end else begin
        fwd.even = wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      val_r <= d;
    end
  end

endmodule

@@ hdl/dfs_clean.sv @@
module dfs_clean (
  input  dfs_pkg::clean_req_t        req,
  output logic [dfs_pkg::LVL_W-1:0]  level
);

  logic [5:0]               sum;
  logic [2:0]               n;
  logic                     spike;
  logic [6:0]               s1;
  logic [6:0]               s2;
  logic [6:0]               x3;
  logic [13:0]              prod;
  logic [dfs_pkg::LVL_W-1:0] avg;

  function automatic logic near(input logic [dfs_pkg::LVL_W-1:0] a,
                                input logic [dfs_pkg::LVL_W-1:0] b);
    logic [dfs_pkg::LVL_W-1:0] diff;
    diff = (a > b) ? a - b : b - a;
    return diff <= 4'd1;
  endfunction

  always_comb begin
    sum = (req.has_right ? 6'(req.right) : 6'd0)
        + (req.has_down  ? 6'(req.down)  : 6'd0)
        + (req.has_left  ? 6'(req.left)  : 6'd0)
        + (req.has_up    ? 6'(req.up)    : 6'd0);
    n = 3'(req.has_right) + 3'(req.has_down) + 3'(req.has_left) + 3'(req.has_up);
    spike = (!req.has_right || !near(req.centre, req.right))
         && (!req.has_down  || !near(req.centre, req.down))
         && (!req.has_left  || !near(req.centre, req.left))
         && (!req.has_up    || !near(req.centre, req.up));
    // round half up: (2*sum + n) / (2*n)
    s1   = 7'(sum) + 7'd1;
    s2   = 7'(sum) + 7'd2;
    x3   = {sum, 1'b0} + 7'd3;
    prod = 14'(x3) * 14'd171;
    case (n)
      3'd1:    avg = sum[3:0];
      3'd2:    avg = s1[4:1];
      3'd3:    avg = prod[13:10];
      3'd4:    avg = s2[5:2];
      default: avg = req.centre;
    endcase
    level = (n == 3'd0 || !spike) ? req.centre : avg;
  end

endmodule

@@ hdl/despeckle_filter_ascii_shade.sv @@
// Order: pixel (r,c) is registered for output when pixel (r+1,c) is taken; the last row leaves
//   after the last input, one pixel per cycle as the output frees.
// Throughput: one item per cycle inside a row while the output is free; after each row the
//   ring of column cells turns back to column 0, and frame end adds a flush plus turning.
// Reset (rst_n low, synchronous): positions, state and output valid clear, width 30 and
//   height 20 return; the column cells keep their contents.
module despeckle_filter_ascii_shade (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [3:0] level
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [6:0] glyph, [10:7] clean_level
  output logic        out_tlast,  // frame_end
  output logic        out_tuser,  // [0] row_end
  input  logic        cfg_we,
  input  logic [0:0]  cfg_addr,
  input  logic [9:0]  cfg_wdata
);

  localparam int MW = dfs_pkg::MAX_WIDTH;
  localparam int CW = dfs_pkg::COL_W;
  localparam int WW = dfs_pkg::WIDTH_W;
  localparam int HW = dfs_pkg::HEIGHT_W;
  localparam int LW = dfs_pkg::LVL_W;

  localparam logic [1:0] S_RUN   = 2'd0;
  localparam logic [1:0] S_WRAP  = 2'd1;
  localparam logic [1:0] S_FLUSH = 2'd2;

  logic [1:0]    state_r, state_nxt;
  logic [CW-1:0] col_r, col_nxt;
  logic [HW-1:0] row_r, row_nxt;
  logic          flush_r, flush_nxt;
  logic [WW-1:0] width_r;
  logic [HW-1:0] height_r;

  logic                      out_valid_r;
  logic [dfs_pkg::GLYPH_W-1:0] glyph_r;
  logic [LW-1:0]             level_r;
  logic                      row_end_r;
  logic                      frame_end_r;

  logic [WW-1:0]   w_eff;
  logic [HW-1:0]   h_eff;
  logic [WW:0]     col_p1;
  logic [HW:0]     row_p1;
  logic            last_col;
  logic            last_row;
  logic [CW-1:0]   col_inc;
  logic            out_free;
  logic            accept_in;
  logic            flush_go;
  logic            shift;
  logic            bank;
  logic [LW-1:0]   lvl_in;

  dfs_pkg::pair_t      cq   [MW];
  dfs_pkg::pair_t      cfwd [MW];
  dfs_pkg::clean_req_t req;
  logic [LW-1:0]       clean_lvl;

  always_comb begin
    if (width_r == '0) begin
      w_eff = WW'(1);
    end else if (width_r > WW'(MW)) begin
      w_eff = WW'(MW);
    end else begin
      w_eff = width_r;
    end
    h_eff    = (height_r == '0) ? HW'(1) : height_r;
    col_p1   = (WW+1)'(col_r) + 1'b1;
    row_p1   = (HW+1)'(row_r) + 1'b1;
    last_col = col_p1 >= {1'b0, w_eff};
    last_row = row_p1 >= {1'b0, h_eff};
    col_inc  = (col_r == CW'(MW - 1)) ? '0 : col_r + 1'b1;
    lvl_in   = (in_tdata[3:0] > dfs_pkg::LVL_MAX) ? dfs_pkg::LVL_MAX : in_tdata[3:0];
  end

  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == S_RUN) && out_free;
  assign accept_in = in_tvalid && in_tready;
  assign flush_go  = (state_r == S_FLUSH) && out_free;
  assign shift     = accept_in || flush_go || (state_r == S_WRAP);
  // the emitted row (the one before the input row) in normal running, the flushed row itself at frame end
  assign bank      = row_r[0] ^ (state_r != S_FLUSH);

  for (genvar i = 0; i < MW; i++) begin : g_cell
    if (i == 0) begin : g_head
      dfs_cell u_cell (
        .clk     (clk),
        .shift   (shift),
        .d       (cfwd[(i + 1) % MW]),
        .wr      (accept_in),
        .wr_bank (row_r[0]),
        .wr_data (lvl_in),
        .q       (cq[i]),
        .fwd     (cfwd[i])
      );
    end else begin : g_body
      dfs_cell u_cell (
        .clk     (clk),
        .shift   (shift),
        .d       (cfwd[(i + 1) % MW]),
        .wr      (1'b0),
        .wr_bank (1'b0),
        .wr_data ('0),
        .q       (cq[i]),
        .fwd     (cfwd[i])
      );
    end
  end

  always_comb begin
    req.centre    = dfs_pkg::pick(cq[0], bank);
    req.up        = dfs_pkg::pick(cq[0], !bank);
    req.right     = dfs_pkg::pick(cq[1], bank);
    req.left      = dfs_pkg::pick(cq[MW-1], bank);
    req.has_right = !last_col;
    req.has_left  = (col_r != '0);
    if (state_r == S_FLUSH) begin
      req.down     = '0;
      req.has_down = 1'b0;
      req.has_up   = (row_r != '0);
    end else begin
      req.down     = lvl_in;
      req.has_down = 1'b1;
      req.has_up   = (row_r[HW-1:1] != '0);
    end
  end

  dfs_clean u_clean (
    .req   (req),
    .level (clean_lvl)
  );

  always_comb begin
    state_nxt = state_r;
    col_nxt   = col_r;
    row_nxt   = row_r;
    flush_nxt = flush_r;
    case (state_r)
      S_RUN: begin
        if (accept_in) begin
          col_nxt = col_inc;
          if (last_col && last_row) begin
            flush_nxt = 1'b1;
            state_nxt = (col_inc == '0) ? S_FLUSH : S_WRAP;
          end else if (last_col) begin
            row_nxt   = row_r + 1'b1;
            flush_nxt = 1'b0;
            state_nxt = (col_inc == '0) ? S_RUN : S_WRAP;
          end
        end
      end
      S_WRAP: begin
        col_nxt = col_inc;
        if (col_inc == '0) begin
          state_nxt = flush_r ? S_FLUSH : S_RUN;
        end
      end
      S_FLUSH: begin
        if (flush_go) begin
          col_nxt = col_inc;
          if (last_col) begin
            row_nxt   = '0;
            flush_nxt = 1'b0;
            state_nxt = (col_inc == '0) ? S_RUN : S_WRAP;
          end
        end
      end
      default: begin
        state_nxt = S_RUN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_RUN;
      col_r    <= '0;
      row_r    <= '0;
      flush_r  <= 1'b0;
      width_r  <= dfs_pkg::WIDTH_RESET;
      height_r <= dfs_pkg::HEIGHT_RESET;
    end else begin
      state_r <= state_nxt;
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      flush_r <= flush_nxt;
      if (cfg_we) begin
        case (cfg_addr)
          dfs_pkg::REG_WIDTH:  width_r  <= cfg_wdata[WW-1:0];
          dfs_pkg::REG_HEIGHT: height_r <= cfg_wdata[HW-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((accept_in && row_r != '0) || flush_go) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((accept_in && row_r != '0) || flush_go) begin
      glyph_r     <= dfs_pkg::shade(clean_lvl);
      level_r     <= clean_lvl;
      row_end_r   <= last_col;
      frame_end_r <= flush_go && last_col;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b0, level_r, glyph_r};
  assign out_tlast  = frame_end_r;
  assign out_tuser  = row_end_r;

endmodule

@@ hdl/dfs_checker.sv @@
module dfs_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic        out_tlast,
  input logic        out_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output item changed while stalled");

  a_ready_room: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !out_tvalid || out_tready)
    else $error("input taken with no room for its result");

  a_frame_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tuser)
    else $error("frame end without row end");

  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[10:7] <= 4'd9 && out_tdata[15:11] == 5'd0)
    else $error("clean level out of range");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

endmodule

bind despeckle_filter_ascii_shade dfs_checker u_dfs_checker (.*);
